/* rtl/assert_macros.svh */
// assertion macros shared by the detector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define DED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define DED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ded_pkg.sv */
// types and constants of the decimating energy detector
`default_nettype none

package ded_pkg;

	// field and register widths
	localparam int RAW_W      = 18;
	localparam int DEC_W      = 8;
	localparam int CNT_W      = 13;
	localparam int PH_W       = 7;
	localparam int SMP_W      = 16;
	localparam int NRG_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RAW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEC     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CNT     = 2'd2;

	// register reset values
	localparam logic [RAW_W-1:0] RAW_LEN_RST = 18'd76800;
	localparam logic [DEC_W-1:0] DEC_RST     = 8'd32;
	localparam logic [CNT_W-1:0] CNT_RST     = 13'd2400;

	// decimation limits
	localparam logic [DEC_W-1:0] DEC_MIN = 8'd1;
	localparam logic [DEC_W-1:0] DEC_MAX = 8'd128;

	// largest number of kept samples per frame
	localparam logic [CNT_W-1:0] MAX_KEPT = 13'd4800;

	// signal window = floor(count * 62670 / 100000); the division is a
	// multiply by ceil(2^46 / 100000) and a shift, exact for products < 2^29
	localparam int PROD_W    = 29;
	localparam int RECIP_W   = 30;
	localparam int SCALE_W   = PROD_W + RECIP_W;
	localparam int SIG_SHIFT = 46;
	localparam logic [15:0]        SIG_NUM   = 16'd62670;
	localparam logic [RECIP_W-1:0] SIG_RECIP = 30'd703687442;

	// noise energy is compared after this right shift
	localparam int NOISE_SHIFT = 6;

	// short queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_re;
		logic signed [SMP_W-1:0] sample_im;
	} sample_t;

	typedef struct packed {
		logic              detected;
		logic [NRG_W-1:0]  signal_energy;
		logic [NRG_W-1:0]  noise_energy;
	} result_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic signed [SMP_W-1:0] sample_re;
		logic signed [SMP_W-1:0] sample_im;
		logic [CNT_W-1:0]        divisor;
		logic                    to_noise;
		logic                    accumulate;
		logic                    frame_end;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

/* rtl/ded_stream_if.sv */
// valid/ready stream channel carrying one item per handshake
`default_nettype none

interface ded_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ded_front.sv */
// front: configuration, frame and decimation counters, window classification
`default_nettype none

`include "assert_macros.svh"

module ded_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ded_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [ded_pkg::CFG_DATA_W-1:0] cfg_data,
	ded_stream_if.sink                         smp,
	output logic                               push,
	output ded_pkg::queue_entry_t              push_entry,
	input  wire ded_pkg::queue_status_t        q_status
);

	logic [ded_pkg::RAW_W-1:0]   raw_len_q;
	logic [ded_pkg::DEC_W-1:0]   dec_q;
	logic [ded_pkg::CNT_W-1:0]   cnt_q;
	logic [1:0]                  settle_q;
	logic [ded_pkg::RAW_W-1:0]   raw_idx_q;
	logic [ded_pkg::PH_W-1:0]    phase_q;
	logic [ded_pkg::CNT_W-1:0]   kept_q;
	logic [ded_pkg::CNT_W-1:0]   sws_q;
	logic [ded_pkg::PROD_W-1:0]  prod_s1;
	logic [ded_pkg::CNT_W-1:0]   sws_s2;

	logic [ded_pkg::CNT_W-1:0]   eff_cnt;
	logic [ded_pkg::SCALE_W-1:0] scaled;
	logic [ded_pkg::DEC_W-1:0]   dec_eff;
	logic [ded_pkg::DEC_W-1:0]   phase_inc;
	logic [ded_pkg::PH_W-1:0]    phase_nxt;
	logic [ded_pkg::CNT_W-1:0]   sws_cur;
	logic [ded_pkg::CNT_W-1:0]   noise_div;
	logic [ded_pkg::CNT_W-1:0]   div;
	logic [ded_pkg::RAW_W:0]     raw_inc;
	logic                        keep;
	logic                        in_sig;
	logic                        add;
	logic                        last;
	logic                        accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_len_q <= ded_pkg::RAW_LEN_RST;
			dec_q     <= ded_pkg::DEC_RST;
			cnt_q     <= ded_pkg::CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ded_pkg::REG_RAW_LEN: raw_len_q <= cfg_data[ded_pkg::RAW_W-1:0];
				ded_pkg::REG_DEC:     dec_q     <= cfg_data[ded_pkg::DEC_W-1:0];
				ded_pkg::REG_CNT:     cnt_q     <= cfg_data[ded_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign eff_cnt = (cnt_q > ded_pkg::MAX_KEPT) ? ded_pkg::MAX_KEPT : cnt_q;

	// signal window size, recomputed from the count over two stages
	assign scaled = ded_pkg::SCALE_W'(prod_s1) * ded_pkg::SCALE_W'(ded_pkg::SIG_RECIP);

	always_ff @(posedge clk) begin
		prod_s1 <= ded_pkg::PROD_W'(eff_cnt) * ded_pkg::PROD_W'(ded_pkg::SIG_NUM);
		sws_s2  <= scaled[ded_pkg::SIG_SHIFT +: ded_pkg::CNT_W];
	end

	// input held off until the window size has caught up with a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (cfg_we) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// classification of the item on the input
	always_comb begin
		if (dec_q == '0) begin
			dec_eff = ded_pkg::DEC_MIN;
		end else if (dec_q > ded_pkg::DEC_MAX) begin
			dec_eff = ded_pkg::DEC_MAX;
		end else begin
			dec_eff = dec_q;
		end
		phase_inc = {1'b0, phase_q} + ded_pkg::DEC_W'(1);
		phase_nxt = (phase_inc >= dec_eff) ? '0 : phase_inc[ded_pkg::PH_W-1:0];
		sws_cur   = (raw_idx_q == '0) ? sws_s2 : sws_q;
		keep      = (phase_q == '0) && (kept_q < eff_cnt);
		in_sig    = kept_q < sws_cur;
		noise_div = (eff_cnt > sws_cur) ? eff_cnt - sws_cur : '0;
		div       = in_sig ? sws_cur : noise_div;
		add       = keep && (div != '0);
		raw_inc   = {1'b0, raw_idx_q} + (ded_pkg::RAW_W+1)'(1);
		last      = raw_inc >= {1'b0, raw_len_q};
	end

	assign smp.ready = (settle_q == 2'd0) && !q_status.full;
	assign accept    = smp.valid && smp.ready;
	assign push      = accept && (add || last);

	always_comb begin
		push_entry.sample_re  = smp.data.sample_re;
		push_entry.sample_im  = smp.data.sample_im;
		push_entry.divisor    = div;
		push_entry.to_noise   = !in_sig;
		push_entry.accumulate = add;
		push_entry.frame_end  = last;
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_idx_q <= '0;
			phase_q   <= '0;
			kept_q    <= '0;
			sws_q     <= '0;
		end else if (accept) begin
			if (last) begin
				raw_idx_q <= '0;
				phase_q   <= '0;
				kept_q    <= '0;
				sws_q     <= '0;
			end else begin
				raw_idx_q <= raw_inc[ded_pkg::RAW_W-1:0];
				phase_q   <= phase_nxt;
				sws_q     <= sws_cur;
				if (keep) begin
					kept_q <= kept_q + ded_pkg::CNT_W'(1);
				end
			end
		end
	end

	`DED_ASSERT_NEXT(a_cfg_holds_input, clk, arst_n, cfg_we, !smp.ready,
		"input taken while window size settles")
	`DED_ASSERT_NOW(a_push_has_work, clk, arst_n, push,
		push_entry.accumulate || push_entry.frame_end, "queued item carries no work")

endmodule

`default_nettype wire

/* rtl/ded_queue.sv */
// short queue of classified items between front and back
`default_nettype none

`include "assert_macros.svh"

module ded_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ded_pkg::queue_entry_t push_entry,
	input  wire logic                  pop,
	output ded_pkg::queue_entry_t      head,
	output ded_pkg::queue_status_t     status
);

	localparam int PTR_W = $clog2(ded_pkg::QUEUE_DEPTH);
	localparam int LVL_W = $clog2(ded_pkg::QUEUE_DEPTH + 1);

	ded_pkg::queue_entry_t entries_q [ded_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [LVL_W-1:0]      level_q;

	assign status.full  = level_q == LVL_W'(ded_pkg::QUEUE_DEPTH);
	assign status.empty = level_q == '0;
	assign head         = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	`DED_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !status.full, "push into full queue")
	`DED_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !status.empty, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/ded_back.sv */
// back: energy, bit-serial division, saturating accumulation, result register
`default_nettype none

`include "assert_macros.svh"

module ded_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ded_pkg::queue_entry_t  head,
	input  wire ded_pkg::queue_status_t q_status,
	output logic                        pop,
	ded_stream_if.source                res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam int STEP_W = $clog2(ded_pkg::NRG_W);

	logic [2:0]                 state_q;
	logic [ded_pkg::NRG_W-1:0]  sq_re_q;
	logic [ded_pkg::NRG_W-1:0]  sq_im_q;
	logic [ded_pkg::NRG_W-1:0]  dvd_q;
	logic [ded_pkg::CNT_W-1:0]  rem_q;
	logic [ded_pkg::CNT_W-1:0]  divisor_q;
	logic                       to_noise_q;
	logic                       frame_end_q;
	logic [STEP_W-1:0]          step_q;
	logic [ded_pkg::NRG_W-1:0]  sig_acc_q;
	logic [ded_pkg::NRG_W-1:0]  noise_acc_q;
	logic                       res_valid_q;
	ded_pkg::result_t           res_data_q;

	logic signed [ded_pkg::NRG_W-1:0] sq_re;
	logic signed [ded_pkg::NRG_W-1:0] sq_im;
	logic [ded_pkg::CNT_W:0]          trial;
	logic                             ge;
	logic [ded_pkg::NRG_W-1:0]        acc_sel;
	logic [ded_pkg::NRG_W:0]          acc_sum;
	logic [ded_pkg::NRG_W-1:0]        acc_sat;
	logic                             out_free;
	logic                             load;

	assign sq_re = head.sample_re * head.sample_re;
	assign sq_im = head.sample_im * head.sample_im;

	// one quotient bit per cycle
	assign trial = {rem_q, dvd_q[ded_pkg::NRG_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};

	assign acc_sel = to_noise_q ? noise_acc_q : sig_acc_q;
	assign acc_sum = {1'b0, acc_sel} + {1'b0, dvd_q};
	assign acc_sat = acc_sum[ded_pkg::NRG_W] ? '1 : acc_sum[ded_pkg::NRG_W-1:0];

	assign out_free = !res_valid_q || res.ready;
	assign pop      = (state_q == ST_IDLE) && !q_status.empty;
	assign load     = (state_q == ST_EMIT) && out_free;

	always_ff @(posedge clk) begin
		if (pop) begin
			sq_re_q     <= sq_re;
			sq_im_q     <= sq_im;
			divisor_q   <= head.divisor;
			to_noise_q  <= head.to_noise;
			frame_end_q <= head.frame_end;
		end
		if (state_q == ST_SUM) begin
			dvd_q  <= sq_re_q + sq_im_q;
			rem_q  <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q  <= {dvd_q[ded_pkg::NRG_W-2:0], ge};
			rem_q  <= ge ? ded_pkg::CNT_W'(trial - {1'b0, divisor_q})
				: trial[ded_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			sig_acc_q   <= '0;
			noise_acc_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= head.accumulate ? ST_SUM : ST_EMIT;
					end
				end
				ST_SUM: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == '1) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (to_noise_q) begin
						noise_acc_q <= acc_sat;
					end else begin
						sig_acc_q <= acc_sat;
					end
					state_q <= frame_end_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						sig_acc_q   <= '0;
						noise_acc_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register parts the back from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_data_q.detected      <= sig_acc_q < (noise_acc_q >> ded_pkg::NOISE_SHIFT);
			res_data_q.signal_energy <= sig_acc_q;
			res_data_q.noise_energy  <= noise_acc_q;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	`DED_ASSERT_NOW(a_div_nonzero, clk, arst_n, state_q == ST_DIV, divisor_q != '0,
		"division by zero window size")
	`DED_ASSERT_NEXT(a_acc_cleared, clk, arst_n, load,
		(sig_acc_q == '0) && (noise_acc_q == '0), "accumulators not cleared after result")

endmodule

`default_nettype wire

/* rtl/decimating_energy_detector.sv */
// top level of the decimating energy detector
`default_nettype none

// Decimating energy detector. Raw complex samples of a frame enter on smp, one
// item per handshake; the front keeps one raw sample in every decimation_factor
// (first one kept) until decimated_count samples are kept, assigns each kept
// sample to the signal window (the first floor(0.6267 * count)) or the noise
// window, and queues it with its window size as divisor. The back squares and
// sums the two parts, divides by the window size one quotient bit per cycle and
// adds the quotient to a saturating 32-bit accumulator. After the last raw
// sample of the frame one item leaves on res: both energies and detected, set
// when signal energy is below noise energy shifted right by 6; the
// accumulators then restart from zero. Samples that are not kept are taken one
// per cycle while the queue is not full. A kept sample passes through the back
// in steps (square, sum, 32 division steps, accumulate); the four-entry queue
// lets the front run on meanwhile. At the end of a frame the result moves into
// the output register, which holds it while the next frame streams in. After
// reset and after every configuration write the input is held off while the
// window size is recomputed. Registers are written through cfg_we, cfg_idx
// and cfg_data: index 0 raw frame length, 1 decimation factor, 2 kept-sample
// count.
module decimating_energy_detector (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ded_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ded_pkg::CFG_DATA_W-1:0] cfg_data,
	ded_stream_if.sink                          smp,
	ded_stream_if.source                        res
);

	// front to queue
	logic                   push;
	ded_pkg::queue_entry_t  push_entry;

	// queue to back
	logic                   pop;
	ded_pkg::queue_entry_t  head;
	ded_pkg::queue_status_t q_status;

	// counters, configuration and window classification
	ded_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.smp        (smp),
		.push       (push),
		.push_entry (push_entry),
		.q_status   (q_status)
	);

	// only kept samples with a nonzero divisor and frame ends are queued
	ded_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// divider, accumulators and result register
	ded_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.res      (res)
	);

endmodule

`default_nettype wire

/* sim/ded_energy_monitor.sv */
// frame-level energy predictor and result comparison for the decimating energy detector
`timescale 1ns / 100ps

module ded_energy_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ded_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ded_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           smp_valid,
	input  logic                           smp_ready,
	input  ded_pkg::sample_t               smp_data,
	input  logic                           res_valid,
	input  logic                           res_ready,
	input  ded_pkg::result_t               res_data,
	output int                             owed,
	output int                             mismatches
);

	localparam longint SIG_DEN = 100000;

	// register shadows
	logic [ded_pkg::RAW_W-1:0] frame_len;
	logic [ded_pkg::DEC_W-1:0] decim;
	logic [ded_pkg::CNT_W-1:0] keep_cnt;

	// frame progress and running energies
	logic [ded_pkg::RAW_W-1:0] raw_pos;
	logic [ded_pkg::PH_W-1:0]  phase;
	logic [ded_pkg::CNT_W-1:0] kept_pos;
	logic [ded_pkg::CNT_W-1:0] sig_len;
	logic [ded_pkg::NRG_W-1:0] sig_sum;
	logic [ded_pkg::NRG_W-1:0] noise_sum;

	ded_pkg::result_t owed_verdicts[$];
	int               errors = 0;

	assign mismatches = errors;

	function automatic logic [ded_pkg::NRG_W-1:0] sat_sum(
			input logic [ded_pkg::NRG_W-1:0] acc,
			input logic [ded_pkg::NRG_W-1:0] add);
		logic [ded_pkg::NRG_W:0] total;
		total = {1'b0, acc} + {1'b0, add};
		return total[ded_pkg::NRG_W] ? '1 : total[ded_pkg::NRG_W-1:0];
	endfunction

	function automatic void clear_frame();
		raw_pos   = '0;
		phase     = '0;
		kept_pos  = '0;
		sig_len   = '0;
		sig_sum   = '0;
		noise_sum = '0;
	endfunction

	// advance the frame by one raw sample, queueing the verdict on the last one
	function automatic void fold_sample(input ded_pkg::sample_t s);
		logic [ded_pkg::CNT_W-1:0] span;
		logic [ded_pkg::CNT_W-1:0] noise_div;
		logic [ded_pkg::DEC_W-1:0] stride;
		logic [ded_pkg::NRG_W-1:0] power;
		int                        re;
		int                        im;
		ded_pkg::result_t          verdict;
		span   = (keep_cnt > ded_pkg::MAX_KEPT) ? ded_pkg::MAX_KEPT : keep_cnt;
		stride = (decim == '0) ? ded_pkg::DEC_MIN
			: ((decim > ded_pkg::DEC_MAX) ? ded_pkg::DEC_MAX : decim);
		if (raw_pos == '0)
			sig_len = ded_pkg::CNT_W'((64'(ded_pkg::SIG_NUM) * 64'(span)) / SIG_DEN);
		if (phase == '0 && kept_pos < span) begin
			re    = s.sample_re;
			im    = s.sample_im;
			power = ded_pkg::NRG_W'(re * re) + ded_pkg::NRG_W'(im * im);
			if (kept_pos < sig_len) begin
				sig_sum = sat_sum(sig_sum, power / sig_len);
			end else begin
				noise_div = (span > sig_len) ? span - sig_len : '0;
				if (noise_div != '0)
					noise_sum = sat_sum(noise_sum, power / noise_div);
			end
			kept_pos = kept_pos + 1'b1;
		end
		phase = (32'(phase) + 1 >= 32'(stride)) ? '0 : phase + 1'b1;
		if (32'(raw_pos) + 1 >= 32'(frame_len)) begin
			verdict.detected      = sig_sum < (noise_sum >> ded_pkg::NOISE_SHIFT);
			verdict.signal_energy = sig_sum;
			verdict.noise_energy  = noise_sum;
			owed_verdicts.push_back(verdict);
			clear_frame();
		end else begin
			raw_pos = raw_pos + 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ded_pkg::result_t want;
		if (!arst_n) begin
			frame_len = ded_pkg::RAW_LEN_RST;
			decim     = ded_pkg::DEC_RST;
			keep_cnt  = ded_pkg::CNT_RST;
			clear_frame();
			owed_verdicts.delete();
		end else begin
			if (smp_valid && smp_ready)
				fold_sample(smp_data);
			if (res_valid && res_ready) begin
				if (owed_verdicts.size() == 0) begin
					$error("result with no frame outstanding: %p", res_data);
					errors++;
				end else begin
					want = owed_verdicts.pop_front();
					if (res_data.detected !== want.detected) begin
						$error("detected: expected %0d, actual %0d",
							want.detected, res_data.detected);
						errors++;
					end
					if (res_data.signal_energy !== want.signal_energy) begin
						$error("signal_energy: expected %0d, actual %0d",
							want.signal_energy, res_data.signal_energy);
						errors++;
					end
					if (res_data.noise_energy !== want.noise_energy) begin
						$error("noise_energy: expected %0d, actual %0d",
							want.noise_energy, res_data.noise_energy);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					ded_pkg::REG_RAW_LEN: frame_len = cfg_data[ded_pkg::RAW_W-1:0];
					ded_pkg::REG_DEC:     decim     = cfg_data[ded_pkg::DEC_W-1:0];
					ded_pkg::REG_CNT:     keep_cnt  = cfg_data[ded_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
		end
		owed <= owed_verdicts.size();
	end

endmodule

/* sim/decimating_energy_detector_tb.sv */
// top-level testbench of the decimating energy detector: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module decimating_energy_detector_tb;

	localparam int ITEM_GOAL   = 1100;
	localparam int FRAME_GOAL  = 48;
	// the back can hold four queued kept samples plus one in flight
	localparam int SETTLE      = 250;
	localparam int HOLD_CYCLES = 3000;
	localparam int IDLE_PCT    = 28;
	localparam int CYCLE_LIMIT = 1000000;

	// register select masks for write_regs
	localparam bit [2:0] SET_LEN = 3'b001 << ded_pkg::REG_RAW_LEN;
	localparam bit [2:0] SET_DEC = 3'b001 << ded_pkg::REG_DEC;
	localparam bit [2:0] SET_CNT = 3'b001 << ded_pkg::REG_CNT;
	localparam bit [2:0] SET_ALL = SET_LEN | SET_DEC | SET_CNT;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [ded_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [ded_pkg::CFG_DATA_W-1:0] cfg_data;

	int owed;
	int mismatches;
	int cycles = 0;
	int sent = 0;
	int frames_done = 0;

	// calm switches idling off on both sides; hold_reqs asks the receiver for a long stall
	bit calm = 1'b0;
	int hold_reqs = 0;
	int holds_done = 0;

	ded_stream_if #(.payload_t(ded_pkg::sample_t)) smp ();
	ded_stream_if #(.payload_t(ded_pkg::result_t)) res ();

	decimating_energy_detector uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.smp      (smp),
		.res      (res)
	);

	ded_energy_monitor energy_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.smp_valid  (smp.valid),
		.smp_ready  (smp.ready),
		.smp_data   (smp.data),
		.res_valid  (res.valid),
		.res_ready  (res.ready),
		.res_data   (res.data),
		.owed       (owed),
		.mismatches (mismatches)
	);

	always #6 clk = ~clk;

	// watchdog: a correct run finishes far inside this
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random back-pressure, or one long stall when asked
	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_reqs) begin
				res.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				holds_done++;
			end else begin
				res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// offer one item, with random idle cycles ahead of it, and wait until it is taken;
	// valid stays high afterwards so back-to-back items need no extra step
	task automatic send(input ded_pkg::sample_t s);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			smp.valid <= 1'b0;
			@(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.data  <= s;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		sent++;
	endtask

	// stop offering, wait for every outstanding result, then let the back run dry;
	// the first edge lets the monitor count in the last accepted item
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write the selected registers on consecutive edges; only called with the block idle
	task automatic write_regs(input bit [2:0] sel, input logic [ded_pkg::RAW_W-1:0] len,
			input logic [ded_pkg::DEC_W-1:0] dec, input logic [ded_pkg::CNT_W-1:0] cnt);
		if (sel[ded_pkg::REG_RAW_LEN]) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= ded_pkg::REG_RAW_LEN;
			cfg_data <= ded_pkg::CFG_DATA_W'(len);
			@(posedge clk);
		end
		if (sel[ded_pkg::REG_DEC]) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= ded_pkg::REG_DEC;
			cfg_data <= ded_pkg::CFG_DATA_W'(dec);
			@(posedge clk);
		end
		if (sel[ded_pkg::REG_CNT]) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= ded_pkg::REG_CNT;
			cfg_data <= ded_pkg::CFG_DATA_W'(cnt);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// hushed samples stay within +-8 so a quiet signal window can trip detection
	function automatic ded_pkg::sample_t pick_sample(input bit hushed);
		ded_pkg::sample_t s;
		logic [15:0]      part [2];
		for (int k = 0; k < 2; k++) begin
			part[k] = 16'($urandom);
			if (hushed) begin
				part[k] = {{12{part[k][3]}}, part[k][3:0]};
			end else if ($urandom_range(99) < 12) begin
				case ($urandom_range(3))
					0: part[k] = 16'h8000;
					1: part[k] = 16'h7FFF;
					2: part[k] = 16'h0000;
					default: part[k] = 16'hFFFF;
				endcase
			end
		end
		s.sample_re = part[0];
		s.sample_im = part[1];
		return s;
	endfunction

	initial begin
		int raw;
		int dec;
		int cnt;
		int len;
		int frames;
		int twist_at;
		bit calm_phase;
		bit calm_used;
		bit hushed;

		calm_used = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = ded_pkg::REG_RAW_LEN;
		cfg_data  = '0;
		smp.valid = 1'b0;
		smp.data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: decimation 32 keeps only the first of these three
		send({16'h8000, 16'h8000});
		send({16'h7FFF, 16'h7FFF});
		send({16'h0000, 16'h0000});
		drain();
		// frame length cut below the current position mid-frame: next item closes the frame
		write_regs(SET_LEN, 18'd2, '0, '0);
		send({16'h8000, 16'h7FFF});

		// noise saturation: longest frame, one signal sample, then the kept count is
		// raised one step per sample so the noise divisor stays tiny
		drain();
		write_regs(SET_ALL, 18'h3FFFF, 8'd1, 13'd2);
		send({16'h0001, 16'h0000});
		send({16'h8000, 16'h8000});
		for (int n = 3; n <= 6; n++) begin
			drain();
			write_regs(SET_CNT, '0, '0, 13'(n));
			send({16'h8000, 16'h8000});
		end
		// zero frame length: every item is the last of its frame
		drain();
		write_regs(SET_LEN, 18'd0, '0, '0);
		repeat (3) send(pick_sample(1'b0));

		// decimation 0 behaves as 1
		drain();
		write_regs(SET_ALL, 18'd3, 8'd0, 13'd3);
		repeat (3) send(pick_sample(1'b0));
		// kept count 0: nothing accumulates; decimation above the ceiling
		drain();
		write_regs(SET_ALL, 18'd2, 8'd255, 13'd0);
		repeat (2) send(pick_sample(1'b0));
		// kept count 1: empty signal window, the one sample goes to noise
		drain();
		write_regs(SET_ALL, 18'd2, 8'd1, 13'd1);
		repeat (2) send(pick_sample(1'b0));
		// kept count beyond the maximum, far more than the frame can deliver
		drain();
		write_regs(SET_ALL, 18'd3, 8'd200, 13'h1FFF);
		repeat (3) send(pick_sample(1'b0));
		drain();
		write_regs(SET_ALL, 18'd2, 8'd128, 13'd4800);
		repeat (2) send(pick_sample(1'b0));

		// back-pressure: one result per item while the receiver stalls for a long time,
		// so the output register and queue fill and the input is held off
		drain();
		write_regs(SET_ALL, 18'd1, 8'd1, 13'd16);
		hold_reqs <= hold_reqs + 1;
		repeat (20) send(pick_sample(1'b0));
		// sender waits here until every result has come out
		drain();

		// random phases of whole frames, each with fresh settings
		while (sent < ITEM_GOAL || frames_done < FRAME_GOAL) begin
			calm_phase = !calm_used && sent >= 500;
			case ($urandom_range(9))
				0: raw = $urandom_range(0, 1);
				1: raw = $urandom_range(49, 160);
				default: raw = $urandom_range(2, 48);
			endcase
			case ($urandom_range(9))
				0: dec = $urandom_range(0, 255);
				1: dec = $urandom_range(1) ? 0 : 128;
				default: dec = $urandom_range(1, 4);
			endcase
			case ($urandom_range(9))
				0: cnt = $urandom_range(0, 8191);
				1: cnt = $urandom_range(0, 2);
				default: cnt = $urandom_range(2, 40);
			endcase
			if (calm_phase)
				raw = $urandom_range(30, 48);

			drain();
			write_regs(SET_ALL, ded_pkg::RAW_W'(raw), ded_pkg::DEC_W'(dec),
				ded_pkg::CNT_W'(cnt));

			len = (raw < 2) ? 1 : raw;
			frames = 160 / len;
			if (frames < 1)
				frames = 1;
			if (frames > 24)
				frames = 24;
			frames = calm_phase ? 4 : $urandom_range(1, frames);
			// now and then a register changes halfway through the first frame
			twist_at = (!calm_phase && len > 3 && $urandom_range(99) < 15) ? len / 2 : -1;
			calm <= calm_phase;
			calm_used |= calm_phase;

			for (int f = 0; f < frames; f++) begin
				hushed = $urandom_range(99) < 40;
				for (int j = 0; j < len; j++) begin
					if (f == 0 && j == twist_at) begin
						drain();
						if ($urandom_range(1))
							write_regs(SET_DEC, '0, ded_pkg::DEC_W'($urandom_range(0, 8)), '0);
						else
							write_regs(SET_CNT, '0, '0, ded_pkg::CNT_W'($urandom_range(0, 48)));
					end
					send(pick_sample(hushed && j * 100 < 63 * len));
				end
			end
			frames_done += frames;
		end

		drain();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/ded_pkg.sv
rtl/ded_stream_if.sv
rtl/ded_front.sv
rtl/ded_queue.sv
rtl/ded_back.sv
rtl/decimating_energy_detector.sv
sim/ded_energy_monitor.sv
sim/decimating_energy_detector_tb.sv
